// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

    localparam int unsigned PeriodW = 16;
    localparam int unsigned CountW  = 8;
    localparam int unsigned SampW   = 7;
    localparam int unsigned IdxW    = 6;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_PLAUSIBLE_FLOOR = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_WARMUP_POLLS    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DETECT_POLLS    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PERIOD_UNIT     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MIN_SPACING     = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_LEAD_TIME       = 3'd5;

    localparam logic [PeriodW-1:0] RST_PLAUSIBLE_FLOOR = 16'd75;
    localparam logic [CountW-1:0]  RST_WARMUP_POLLS    = 8'd5;
    localparam logic [CountW-1:0]  RST_DETECT_POLLS    = 8'd100;
    localparam logic [PeriodW-1:0] RST_PERIOD_UNIT     = 16'd250;
    localparam logic [PeriodW-1:0] RST_MIN_SPACING     = 16'd243;
    localparam logic [PeriodW-1:0] RST_LEAD_TIME       = 16'd237;
    localparam logic [PeriodW-1:0] RST_MIN_PERIOD      = 16'd16384;

    typedef struct packed {
        logic [PeriodW-1:0] plausible_floor;
        logic [CountW-1:0]  warmup_polls;
        logic [CountW-1:0]  detect_polls;
        logic [PeriodW-1:0] period_unit;
        logic [PeriodW-1:0] min_spacing;
        logic [PeriodW-1:0] lead_time;
    } cfg_t;

    typedef struct packed {
        logic               imm;
        logic [SampW-1:0]   n;
        logic [PeriodW-1:0] spacing;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic               start;
        logic [PeriodW-1:0] dividend;
        logic [PeriodW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [PeriodW-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/poll_period_sample_scheduler.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------------
// poll in  | push / full           | poll_period, poll_ack
// result   | empty / pop           | immediate_sample, sample_index, target_time,
//          |                       | last_sample
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A poll is classified combinationally and passes a two-word queue to the emitter.
// The emitter loads a poll, then gives one result a cycle while its results are popped.
// A poll that ends detection holds full through up to three 16-step divisions
// on the shared restoring divider.
// Reset restores the register defaults and the detection state; no clearing pass.
// A stalled result holds the emitter; the front runs on until the queue fills.
module poll_period_sample_scheduler #(
    parameter int unsigned MAX_SAMPLES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [pps_pkg::PeriodW-1:0]   poll_period,
    input  logic                          poll_ack,
    output logic                          empty,
    input  logic                          pop,
    output logic                          immediate_sample,
    output logic [pps_pkg::IdxW-1:0]      sample_index,
    output logic [pps_pkg::PeriodW-1:0]   target_time,
    output logic                          last_sample,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pps_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [pps_pkg::PeriodW-1:0]   cfg_data
);
    import pps_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    accept;
    logic    front_busy;
    logic    cmd_push;
    cmd_t    cmd_in;
    cmd_t    cmd_out;
    logic    cmd_pop;
    q_stat_t q_stat;

    assign cfg_ready = 1'b1;
    assign full      = front_busy || q_stat.full;
    assign accept    = push && !full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PLAUSIBLE_FLOOR: cfg_next.plausible_floor = cfg_data;
                REG_WARMUP_POLLS:    cfg_next.warmup_polls    = cfg_data[CountW-1:0];
                REG_DETECT_POLLS:    cfg_next.detect_polls    = cfg_data[CountW-1:0];
                REG_PERIOD_UNIT:     cfg_next.period_unit     = cfg_data;
                REG_MIN_SPACING:     cfg_next.min_spacing     = cfg_data;
                REG_LEAD_TIME:       cfg_next.lead_time       = cfg_data;
                default:             cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plausible_floor <= RST_PLAUSIBLE_FLOOR;
            cfg_reg.warmup_polls    <= RST_WARMUP_POLLS;
            cfg_reg.detect_polls    <= RST_DETECT_POLLS;
            cfg_reg.period_unit     <= RST_PERIOD_UNIT;
            cfg_reg.min_spacing     <= RST_MIN_SPACING;
            cfg_reg.lead_time       <= RST_LEAD_TIME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pps_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .poll_period (poll_period),
        .poll_ack    (poll_ack),
        .busy        (front_busy),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    pps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .stat  (q_stat)
    );

    pps_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .lead_time        (cfg_reg.lead_time),
        .cmd              (cmd_out),
        .cmd_avail        (!q_stat.empty),
        .cmd_pop          (cmd_pop),
        .pop              (pop),
        .empty            (empty),
        .immediate_sample (immediate_sample),
        .sample_index     (sample_index),
        .target_time      (target_time),
        .last_sample      (last_sample)
    );

`ifndef SYNTHESIS
    a_imm_single : assert property (@(posedge clk) disable iff (!rst_n)
        !empty && immediate_sample |-> last_sample && sample_index == '0
                                       && target_time == '0)
        else $error("immediate word not a single final word");

    a_q_stat : assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    a_q_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !q_stat.full && !front_busy)
        else $error("poll pushed while front unable to take it");

    a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !q_stat.empty)
        else $error("emitter popped an empty queue");
`endif

endmodule

// ===== rtl/core/pps_div.sv =====
module pps_div (
    input  logic             clk,
    input  logic             rst_n,
    input  pps_pkg::div_req_t req,
    output pps_pkg::div_rsp_t rsp
);
    import pps_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [PeriodW-1:0] rem_reg, rem_next;
    logic [PeriodW-1:0] quo_reg, quo_next;
    logic [PeriodW-1:0] dvs_reg, dvs_next;
    logic [PeriodW:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[PeriodW-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd15;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = PeriodW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[PeriodW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PeriodW-1:0];
                quo_next = {quo_reg[PeriodW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/pps_front.sv =====
module pps_front #(
    parameter int unsigned MAX_SAMPLES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pps_pkg::cfg_t                cfg,
    input  logic                         accept,
    input  logic [pps_pkg::PeriodW-1:0]  poll_period,
    input  logic                         poll_ack,
    output logic                         busy,
    output logic                         cmd_push,
    output pps_pkg::cmd_t                cmd
);
    import pps_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE    = 4'b0001,
        F_DIV_Q   = 4'b0010,
        F_DIV_SP  = 4'b0100,
        F_DIV_FIX = 4'b1000
    } front_state_t;

    localparam logic [SampW-1:0] MaxN = SampW'(MAX_SAMPLES);

    front_state_t       state_reg, state_next;
    logic               det_reg, det_next;
    logic [CountW-1:0]  cnt_reg, cnt_next;
    logic [PeriodW-1:0] min_reg, min_next;
    logic [SampW-1:0]   n_reg, n_next;
    logic [PeriodW-1:0] sp_reg, sp_next;
    logic [CountW-1:0]  cnt_inc;
    logic [SampW-1:0]   n_calc;
    logic [PeriodW:0]   limit;
    div_req_t           dreq;
    div_rsp_t           drsp;

    pps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        det_next      = det_reg;
        cnt_next      = cnt_reg;
        min_next      = min_reg;
        n_next        = n_reg;
        sp_next       = sp_reg;
        dreq.start    = 1'b0;
        dreq.dividend = min_reg;
        dreq.divisor  = {{(PeriodW-SampW){1'b0}}, n_reg};
        cmd_push      = accept;
        cmd.imm       = 1'b0;
        cmd.n         = n_reg;
        cmd.spacing   = sp_reg;
        cnt_inc       = (cnt_reg == {CountW{1'b1}}) ? cnt_reg : cnt_reg + 8'd1;
        limit         = {1'b0, min_reg} + {2'b0, min_reg[PeriodW-1:1]};
        n_calc        = (drsp.quotient >= {{(PeriodW-SampW){1'b0}}, MaxN}) ? MaxN
                        : drsp.quotient[SampW-1:0] + 7'd1;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (det_reg && poll_ack)
                    begin
                        cnt_next    = cnt_inc;
                        if (cnt_inc > cfg.warmup_polls && poll_period > cfg.plausible_floor
                            && poll_period < min_reg)
                        begin
                            min_next = poll_period;
                        end
                        cmd.imm     = 1'b1;
                        cmd.n       = 7'd1;
                        cmd.spacing = '0;
                        if (cnt_inc >= cfg.detect_polls)
                        begin
                            det_next      = 1'b0;
                            dreq.start    = 1'b1;
                            dreq.dividend = min_next;
                            if (cfg.period_unit == '0)
                            begin
                                n_next       = MaxN;
                                dreq.divisor = {{(PeriodW-SampW){1'b0}}, MaxN};
                                state_next   = F_DIV_SP;
                            end
                            else
                            begin
                                dreq.divisor = cfg.period_unit;
                                state_next   = F_DIV_Q;
                            end
                        end
                    end
                    else if ({1'b0, poll_period} > limit)
                    begin
                        det_next    = 1'b1;
                        cnt_next    = '0;
                        n_next      = 7'd1;
                        sp_next     = '0;
                        cmd.n       = 7'd1;
                        cmd.spacing = '0;
                    end
                end
            end
            F_DIV_Q:
            begin
                if (drsp.done)
                begin
                    n_next       = n_calc;
                    dreq.start   = 1'b1;
                    dreq.divisor = {{(PeriodW-SampW){1'b0}}, n_calc};
                    state_next   = F_DIV_SP;
                end
            end
            F_DIV_SP:
            begin
                if (drsp.done)
                begin
                    sp_next = drsp.quotient;
                    if (drsp.quotient < cfg.min_spacing && n_reg > 7'd1)
                    begin
                        n_next       = n_reg - 7'd1;
                        dreq.start   = 1'b1;
                        dreq.divisor = {{(PeriodW-SampW){1'b0}}, n_reg - 7'd1};
                        state_next   = F_DIV_FIX;
                    end
                    else
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            F_DIV_FIX:
            begin
                if (drsp.done)
                begin
                    sp_next    = drsp.quotient;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != F_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            det_reg   <= 1'b1;
            cnt_reg   <= '0;
            min_reg   <= RST_MIN_PERIOD;
            n_reg     <= 7'd1;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            det_reg   <= det_next;
            cnt_reg   <= cnt_next;
            min_reg   <= min_next;
            n_reg     <= n_next;
            sp_reg    <= sp_next;
        end
    end

endmodule

// ===== rtl/core/pps_queue.sv =====
module pps_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pps_pkg::cmd_t     wdata,
    input  logic              pop,
    output pps_pkg::cmd_t     rdata,
    output pps_pkg::q_stat_t  stat
);
    import pps_pkg::*;

    cmd_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    assign rdata      = mem_reg[rptr_reg];
    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);

endmodule

// ===== rtl/core/pps_back.sv =====
module pps_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pps_pkg::PeriodW-1:0]  lead_time,
    input  pps_pkg::cmd_t                cmd,
    input  logic                         cmd_avail,
    output logic                         cmd_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic                         immediate_sample,
    output logic [pps_pkg::IdxW-1:0]     sample_index,
    output logic [pps_pkg::PeriodW-1:0]  target_time,
    output logic                         last_sample
);
    import pps_pkg::*;

    logic               act_reg, act_next;
    logic               imm_reg, imm_next;
    logic [SampW-1:0]   n_reg, n_next;
    logic [IdxW-1:0]    idx_reg, idx_next;
    logic [PeriodW-1:0] sp_reg, sp_next;
    logic [PeriodW-1:0] acc_reg, acc_next;
    logic               ov_reg, ov_next;
    logic               o_imm_reg, o_imm_next;
    logic [IdxW-1:0]    o_idx_reg, o_idx_next;
    logic [PeriodW-1:0] o_tgt_reg, o_tgt_next;
    logic               o_last_reg, o_last_next;
    logic               is_last;

    always_comb
    begin
        act_next    = act_reg;
        imm_next    = imm_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        sp_next     = sp_reg;
        acc_next    = acc_reg;
        ov_next     = ov_reg;
        o_imm_next  = o_imm_reg;
        o_idx_next  = o_idx_reg;
        o_tgt_next  = o_tgt_reg;
        o_last_next = o_last_reg;
        cmd_pop     = !act_reg && cmd_avail;
        is_last     = imm_reg || (({1'b0, idx_reg} + 7'd1) == n_reg);
        if (cmd_pop)
        begin
            act_next = 1'b1;
            imm_next = cmd.imm;
            n_next   = cmd.n;
            sp_next  = cmd.spacing;
            idx_next = '0;
            acc_next = cmd.spacing;
        end
        if (act_reg && (!ov_reg || pop))
        begin
            ov_next     = 1'b1;
            o_imm_next  = imm_reg;
            o_idx_next  = idx_reg;
            o_tgt_next  = imm_reg ? '0 : acc_reg - lead_time;
            o_last_next = is_last;
            idx_next    = idx_reg + 6'd1;
            acc_next    = acc_reg + sp_reg;
            if (is_last)
            begin
                act_next = 1'b0;
            end
        end
        else if (pop)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        imm_reg    <= imm_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        sp_reg     <= sp_next;
        acc_reg    <= acc_next;
        o_imm_reg  <= o_imm_next;
        o_idx_reg  <= o_idx_next;
        o_tgt_reg  <= o_tgt_next;
        o_last_reg <= o_last_next;
    end

    assign empty            = !ov_reg;
    assign immediate_sample = o_imm_reg;
    assign sample_index     = o_idx_reg;
    assign target_time      = o_tgt_reg;
    assign last_sample      = o_last_reg;

endmodule
